### rtl/srle_pkg.sv
// shared types and constants for the sparse run-length decoder
// no dependencies; used by srle_front, srle_fifo, srle_back and sparse_rle_decoder

package srle_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 15;
    localparam int unsigned LOW_W   = 7;

    // bit of a length byte that announces a second length byte
    localparam logic [BYTE_W-1:0] LONG_FLAG = 8'h80;

    typedef struct packed {
        logic [BYTE_W-1:0]  fill_value;
        logic [COUNT_W-1:0] repeat_count;
        logic               end_of_frame;
        logic               truncated;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result item;
    } t_push;

endpackage

### rtl/srle_front.sv
// front end: parses compressed bytes into value/count results
// depends on srle_pkg

module srle_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [srle_pkg::BYTE_W-1:0]   i_byte,
    input  logic                          i_last,
    output srle_pkg::t_push               o_push
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_TOKEN  = 3'd1;
    localparam logic [2:0] PH_VALUE  = 3'd2;
    localparam logic [2:0] PH_LEN1   = 3'd3;
    localparam logic [2:0] PH_LEN2   = 3'd4;

    logic [2:0]                   r_phase,     n_phase;
    logic [srle_pkg::BYTE_W-1:0]  r_mask,      n_mask;
    logic [srle_pkg::BYTE_W-1:0]  r_zcode,     n_zcode;
    logic [srle_pkg::BYTE_W-1:0]  r_run_value, n_run_value;
    logic [srle_pkg::LOW_W-1:0]   r_len_low,   n_len_low;

    logic [srle_pkg::BYTE_W-1:0]  tok_bits;
    logic [srle_pkg::BYTE_W-1:0]  lit_bits;
    srle_pkg::t_push              push;

    assign tok_bits = i_byte & r_mask;
    assign lit_bits = i_byte & ~r_mask;

    always_comb begin
        n_phase     = r_phase;
        n_mask      = r_mask;
        n_zcode     = r_zcode;
        n_run_value = r_run_value;
        n_len_low   = r_len_low;
        push        = '0;
        unique case (r_phase)
            PH_TOKEN: begin
                if (tok_bits == '0) begin
                    push.valid                  = 1'b1;
                    push.item.fill_value        = i_byte;
                    push.item.repeat_count      = srle_pkg::COUNT_W'(1);
                end else begin
                    if (tok_bits == r_zcode) begin
                        n_run_value = '0;
                        n_phase     = PH_LEN1;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                    if (lit_bits != '0) begin
                        // literal bits carried on the token byte go out first
                        push.valid             = 1'b1;
                        push.item.fill_value   = lit_bits;
                        push.item.repeat_count = srle_pkg::COUNT_W'(1);
                        push.item.truncated    = i_last;
                    end else if (i_last) begin
                        push.valid          = 1'b1;
                        push.item.truncated = 1'b1;
                    end
                end
            end
            PH_VALUE: begin
                n_run_value = i_byte;
                n_phase     = PH_LEN1;
                if (i_last) begin
                    push.valid          = 1'b1;
                    push.item.truncated = 1'b1;
                end
            end
            PH_LEN1: begin
                if ((i_byte & srle_pkg::LONG_FLAG) == '0) begin
                    n_phase                = PH_TOKEN;
                    push.valid             = 1'b1;
                    push.item.fill_value   = r_run_value;
                    push.item.repeat_count = srle_pkg::COUNT_W'(i_byte);
                end else begin
                    n_len_low = i_byte[srle_pkg::LOW_W-1:0];
                    n_phase   = PH_LEN2;
                    if (i_last) begin
                        push.valid          = 1'b1;
                        push.item.truncated = 1'b1;
                    end
                end
            end
            PH_LEN2: begin
                n_phase                = PH_TOKEN;
                push.valid             = 1'b1;
                push.item.fill_value   = r_run_value;
                push.item.repeat_count = {i_byte, r_len_low};
            end
            default: begin
                // header byte; unused codes land here too
                n_mask  = i_byte;
                n_zcode = i_byte & (~i_byte + srle_pkg::BYTE_W'(1));
                n_phase = PH_TOKEN;
                push.valid = i_last;
            end
        endcase
        push.item.end_of_frame = i_last;
        push.valid             = push.valid & i_accept;
        // every byte flagged last closes the frame
        if (i_last) begin
            n_phase = PH_HEADER;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_mask      <= '0;
            r_zcode     <= '0;
            r_run_value <= '0;
            r_len_low   <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_mask      <= n_mask;
            r_zcode     <= n_zcode;
            r_run_value <= n_run_value;
            r_len_low   <= n_len_low;
        end
    end

endmodule

### rtl/srle_fifo.sv
// small result queue between parser and output stage
// depends on srle_pkg

module srle_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srle_pkg::t_push     i_push,
    input  logic                i_pop,
    output srle_pkg::t_result   o_head,
    output logic                o_not_empty,
    output logic                o_full
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    srle_pkg::t_result r_mem [DEPTH];
    logic [IDX_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [IDX_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              do_pop;

    assign do_pop      = i_pop && (r_count != '0);
    assign o_not_empty = (r_count != '0);
    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_head      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + IDX_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + IDX_W'(1);
        end
        if (i_push.valid && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push.valid && do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### rtl/srle_back.sv
// back end: output register feeding the result stream
// depends on srle_pkg

module srle_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srle_pkg::t_result   i_head,
    input  logic                i_not_empty,
    output logic                o_pop,
    input  logic                i_tready,
    output logic                o_tvalid,
    output srle_pkg::t_result   o_item
);

    logic              r_valid;
    srle_pkg::t_result r_item;
    logic              load;

    // refill whenever the register is empty or being drained
    assign load  = i_not_empty && (!r_valid || i_tready);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_head;
        end
    end

    assign o_tvalid = r_valid;
    assign o_item   = r_item;

endmodule

### rtl/sparse_rle_decoder.sv
// top level of the escape-byte run-length decoder
// depends on srle_pkg, srle_front, srle_fifo, srle_back
//
// usage
//   input stream: one compressed byte per beat in i_s_axis_tdata[7:0], tlast marks
//   the final byte of a frame. the first byte of every frame is the escape mask.
//   output stream: one value/count pair per beat; the receiver writes fill_value
//   repeat_count times. tlast marks the last result of a frame, tuser[0] flags a
//   frame that ended inside a run token (count 0 marker or embedded literal).
//   header and partial-token bytes produce no output beat unless they end a frame or carry literal bits.
// timing
//   one byte accepted per cycle while the queue is not full; the parser holds all per-frame state
//   in a few registers and decides each byte in the cycle it is accepted.
//   a result is written into the queue, then loaded into the output register once that register
//   is empty or being drained, and shown on the output from there.
// stalls
//   a FIFO_DEPTH-entry queue plus the output register absorb a stalled receiver;
//   o_s_axis_tready drops only while the queue is full, and a held output beat
//   keeps its payload until taken.
// reset
//   synchronous, active low; the parser goes back to waiting for a header byte,
//   the queue empties and no output beat is offered.

module sparse_rle_decoder #(
    parameter int unsigned FIFO_DEPTH = 4   // result queue entries, 2 or more
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // compressed byte stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_value
    input  logic        i_s_axis_tlast,   // last_of_frame
    // decoded value/count stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] fill_value, [22:8] repeat_count, [23] zero
    output logic        o_m_axis_tlast,   // end_of_frame
    output logic        o_m_axis_tuser    // truncated
);

    logic              in_accept;
    srle_pkg::t_push   push;
    srle_pkg::t_result head;
    srle_pkg::t_result out_item;
    logic              fifo_not_empty;
    logic              fifo_full;
    logic              pop;

    assign o_s_axis_tready = !fifo_full;
    assign in_accept       = i_s_axis_tvalid && !fifo_full;

    srle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_push   (push)
    );

    srle_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop       (pop),
        .o_head      (head),
        .o_not_empty (fifo_not_empty),
        .o_full      (fifo_full)
    );

    srle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_not_empty (fifo_not_empty),
        .o_pop       (pop),
        .i_tready    (i_m_axis_tready),
        .o_tvalid    (o_m_axis_tvalid),
        .o_item      (out_item)
    );

    assign o_m_axis_tdata = {1'b0, out_item.repeat_count, out_item.fill_value};
    assign o_m_axis_tlast = out_item.end_of_frame;
    assign o_m_axis_tuser = out_item.truncated;

endmodule

### rtl/srle_checker.sv
// port-level checks for the run-length decoder
// depends on sparse_rle_decoder (attached by bind)

module srle_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [23:0] o_m_axis_tdata,
    input  logic        o_m_axis_tlast,
    input  logic        o_m_axis_tuser
);

    // a stalled output beat stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // nothing offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // a truncation flag only comes on the closing beat of a frame
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("truncated beat without end of frame");

    // truncated frames close with a count of zero or one
    a_trunc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[22:9] == 14'd0)
        else $error("truncated beat with long count");

    // pad bit stays clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_m_axis_tdata[23])
        else $error("pad bit set");

endmodule

bind sparse_rle_decoder srle_checker u_srle_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
